// ===== sv/p1305_pkg.sv =====
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types and constants for the Poly1305 authenticator.
// ----------------------------------------------------------------------------
package p1305_pkg;
    localparam int unsigned WordW  = 64;
    localparam int unsigned CountW = 5;
    localparam int unsigned AccW   = 130;
    localparam int unsigned LimbW  = 26;
    localparam int unsigned NLimb  = 5;
    localparam int unsigned QDepth = 2;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [WordW-1:0] ClampLo = 64'h0ffffffc0fffffff;
    localparam logic [WordW-1:0] ClampHi = 64'h0ffffffc0ffffffc;
    localparam logic [AccW-1:0]  PrimeP  = 130'h3fffffffffffffffffffffffffffffffb;

    typedef enum logic [CfgIdxW-1:0] {
        REG_R_LO = 2'd0,
        REG_R_HI = 2'd1,
        REG_S_LO = 2'd2,
        REG_S_HI = 2'd3
    } t_reg_idx;

    // classified block handed from front to back
    typedef struct packed {
        logic [AccW-1:0] blk;
        logic            absorb;
        logic            last;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_RED  = 2'd2,
        ST_OUT  = 2'd3
    } t_state;
endpackage

// ===== sv/poly1305_mac.sv =====
// ----------------------------------------------------------------------------
// poly1305_mac
// Poly1305 one-time authenticator over 16-byte blocks.
// ----------------------------------------------------------------------------
//  channel  | valid / ready        | payload
//  in       | i_valid / o_ready    | i_block_low, i_block_high, i_byte_count, i_is_last
//  out      | o_valid / i_ready    | o_tag_low, o_tag_high
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// In the back end a full block is accepted, then takes 5 limb products of 26x128 bits
// and one reduction; the last block adds a tag step.
// A two-entry queue lets the front take beats while the back multiplies.
// Reset clears the accumulator and keys; no result until its beat is taken.
module poly1305_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [p1305_pkg::WordW-1:0]   i_block_low,
    input  logic [p1305_pkg::WordW-1:0]   i_block_high,
    input  logic [p1305_pkg::CountW-1:0]  i_byte_count,
    input  logic                          i_is_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [p1305_pkg::WordW-1:0]   o_tag_low,
    output logic [p1305_pkg::WordW-1:0]   o_tag_high,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [p1305_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [p1305_pkg::WordW-1:0]   i_cfg_data
);
    import p1305_pkg::*;

    logic [WordW-1:0] r_rlo, r_rhi, r_slo, r_shi;
    logic  w_jv, w_jr;
    t_job  w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rlo <= '0; r_rhi <= '0; r_slo <= '0; r_shi <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_R_LO: r_rlo <= i_cfg_data;
                REG_R_HI: r_rhi <= i_cfg_data;
                REG_S_LO: r_slo <= i_cfg_data;
                REG_S_HI: r_shi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    p1305_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_block_low, .i_block_high, .i_byte_count, .i_is_last,
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    p1305_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .i_r({r_rhi & ClampHi, r_rlo & ClampLo}),
        .i_s({r_shi, r_slo}),
        .o_valid, .i_ready, .o_tag_low, .o_tag_high
    );
endmodule

// ===== sv/p1305_front.sv =====
// ----------------------------------------------------------------------------
// p1305_front
// Accepts message beats, masks and pads the block, queues jobs for the back end.
// ----------------------------------------------------------------------------
module p1305_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [p1305_pkg::WordW-1:0] i_block_low,
    input  logic [p1305_pkg::WordW-1:0] i_block_high,
    input  logic [p1305_pkg::CountW-1:0] i_byte_count,
    input  logic                        i_is_last,
    output logic                        o_job_valid,
    input  logic                        i_job_ready,
    output p1305_pkg::t_job             o_job
);
    import p1305_pkg::*;

    t_job        r_q [QDepth];
    logic [0:0]  r_wp, r_rp, n_wp, n_rp;
    logic [1:0]  r_cnt, n_cnt;
    t_job        w_job;
    logic [4:0]  w_cnt;
    logic [127:0] w_data, w_mask, w_pad;
    logic        w_push, w_pop;

    always_comb begin
        w_cnt  = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        w_data = {i_block_high, i_block_low};
        w_mask = '0;
        w_pad  = '0;
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < w_cnt) w_mask[b*8 +: 8] = 8'hff;
            if (5'(b) == w_cnt) w_pad[b*8] = 1'b1;
        end
        // full block: pad bit sits at bit 128
        w_job.blk    = {1'b0, (w_cnt == 5'd16), (w_data & w_mask) | w_pad};
        w_job.absorb = (w_cnt != 5'd0);
        w_job.last   = i_is_last;
    end

    assign o_ready     = (r_cnt != 2'(QDepth));
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_job_valid && i_job_ready;

    always_comb begin
        n_wp  = r_wp + 1'(w_push);
        n_rp  = r_rp + 1'(w_pop);
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) r_q[r_wp] <= w_job;
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDepth)) else $error("queue overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QDepth)) |-> !o_ready) else $error("ready while full");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("count");
endmodule

// ===== sv/p1305_back.sv =====
// ----------------------------------------------------------------------------
// p1305_back
// Accumulator, limb-serial multiply by clamped r, reduction and tag output.
// ----------------------------------------------------------------------------
module p1305_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    output logic                        o_job_ready,
    input  p1305_pkg::t_job             i_job,
    input  logic [127:0]                i_r,
    input  logic [127:0]                i_s,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [p1305_pkg::WordW-1:0] o_tag_low,
    output logic [p1305_pkg::WordW-1:0] o_tag_high
);
    import p1305_pkg::*;

    t_state       r_st, n_st;
    logic [AccW-1:0] r_acc;
    logic [AccW:0] r_h, w_h;     // h < 2^131; bit 130 seeds the product with r << 130
    logic [2:0]   r_i;
    logic [259:0] r_p;
    logic         r_last, r_tv;
    logic [127:0] r_tag;
    logic         w_take;
    logic [LimbW-1:0] w_limb;
    logic [153:0] w_prod;
    logic [131:0] w_f1;
    logic [AccW:0] w_f2;
    logic [AccW:0] w_g;

    assign o_job_ready = (r_st == ST_IDLE) && !r_tv;
    assign w_take      = i_job_valid && o_job_ready;
    assign o_valid     = r_tv;
    assign o_tag_low   = r_tag[63:0];
    assign o_tag_high  = r_tag[127:64];

    always_comb begin
        w_h    = {1'b0, r_acc} + {1'b0, i_job.blk};
        w_limb = r_h[r_i*LimbW +: LimbW];
        w_prod = 154'(w_limb) * 154'(i_r);
        // fold 2^130 = 5 twice
        w_f1 = 132'(r_p[129:0]) + 132'(r_p[259:130]) * 132'd5;
        w_f2 = 131'(w_f1[129:0]) + 131'(w_f1[131:130]) * 131'd5;
        w_g  = (w_f2 >= 131'(PrimeP)) ? w_f2 - 131'(PrimeP) : w_f2;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (w_take) n_st = i_job.absorb ? ST_MUL : (i_job.last ? ST_OUT : ST_IDLE);
            ST_MUL:  if (r_i == 3'(NLimb-1)) n_st = ST_RED;
            ST_RED:  n_st = r_last ? ST_OUT : ST_IDLE;
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_acc <= '0;
            r_tv  <= 1'b0;
            r_i   <= '0;
        end else begin
            r_st <= n_st;
            if (r_tv && i_ready) r_tv <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (w_take) begin
                    r_h    <= w_h;
                    r_last <= i_job.last;
                    r_i    <= '0;
                    r_p    <= w_h[AccW] ? (260'(i_r) << AccW) : '0;
                end
                ST_MUL: begin
                    r_p <= r_p + (260'(w_prod) << (r_i*LimbW));
                    r_i <= r_i + 3'd1;
                end
                ST_RED:  r_acc <= w_g[AccW-1:0];
                ST_OUT: begin
                    r_tag <= r_acc[127:0] + i_s;
                    r_tv  <= 1'b1;
                    r_acc <= '0;
                end
                default: ;
            endcase
        end
    end

    a_acc_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < PrimeP) else $error("accumulator not reduced");
    a_out_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT) |=> (r_acc == '0 && r_tv)) else $error("tag step");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> !o_job_ready) else $error("took job with tag pending");
endmodule
